[design/ssdf_pkg.sv]
// Shared types, codes and default sizes of the typed slot store.
package ssdf_pkg;

  // Default sizes handed to the top level's parameters
  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned TYPE_COUNT_DEF = 1;
  localparam int unsigned VALUE_BITS_DEF = 64;

  // Tag of a slot that holds nothing
  localparam logic [2:0] TAG_EMPTY = 3'd7;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_DEL   = 2'd2,
    OP_CLEAN = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_PENDING   = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_NO_CLEAN  = 3'd5,
    ST_BAD_DEL   = 3'd6
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [2:0]  type_id;
    logic [9:0]  slot_in;
    logic [63:0] value_in;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot_out;
    logic [63:0] value_out;
  } out_t;

endpackage

[design/ssdf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data, hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/slot_store_deferred_free_core.sv]
// Top level of the typed slot store with deferred reclamation.
//
//   channel   ports                         transfer
//   command   start, busy, item_i           edge with start high and busy low
//   result    done_o, result_o              edge that ends the cycle done_o is high
//
// A command reads, then writes back: the accept cycle reads the slot entry from the
// meta and value RAMs, the next cycle decides and writes back. The result shows
// one cycle after that, for one cycle, while busy is already low again, so a new
// command may be taken every second cycle. Reset needs no clearing pass: the bump
// counter marks which slots were ever written, and unwritten slots read as empty.
// The receiver cannot stall; the result register is overwritten by the next command.
module slot_store_deferred_free_core #(
  parameter int unsigned SLOTS      = ssdf_pkg::SLOTS_DEF,
  parameter int unsigned TYPE_COUNT = ssdf_pkg::TYPE_COUNT_DEF,
  parameter int unsigned VALUE_BITS = ssdf_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ssdf_pkg::in_t  item_i,
  output logic           done_o,
  output ssdf_pkg::out_t result_o
);

  import ssdf_pkg::*;

  // Slot index, list pointer (with null) and compare widths
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned CW = (PW > 10) ? PW : 10;
  // Meta word: {link, pending, tag}
  localparam int unsigned MW = PW + 4;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  in_t    item_q;
  out_t   res_q, res_d;
  logic   done_q;

  logic [PW-1:0] bump_q, bump_d;
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] dead_head_q, dead_head_d;
  logic [PW-1:0] dead_tail_q, dead_tail_d;

  logic            accept;
  logic [CW-1:0]   slot_in_ext;
  logic [IW-1:0]   rd_addr;
  logic [MW-1:0]   meta_rdata;
  logic [VALUE_BITS-1:0] val_rdata;

  logic            meta_we;
  logic [IW-1:0]   meta_waddr;
  logic [MW-1:0]   meta_wdata;
  logic            val_we;
  logic [IW-1:0]   val_waddr;

  logic [CW-1:0]   slot_q_ext;
  logic [CW-1:0]   alloc_ext;
  logic [PW-1:0]   alloc_idx;
  logic            slot_used;
  logic [2:0]      rd_tag;
  logic            rd_pend;
  logic [PW-1:0]   rd_link;
  logic [2:0]      cur_tag;
  logic            cur_pend;
  logic            type_ok;
  logic            free_avail;
  logic            bump_avail;

  assign busy   = (state_q == S_EXEC);
  assign accept = start & ~busy;

  // Address the slot entry that the incoming command touches
  assign slot_in_ext = CW'(item_i.slot_in);
  always_comb begin
    unique case (item_i.opcode)
      OP_SET:         rd_addr = free_head_q[IW-1:0];
      OP_GET, OP_DEL: rd_addr = slot_in_ext[IW-1:0];
      OP_CLEAN:       rd_addr = dead_tail_q[IW-1:0];
      default:        rd_addr = '0;
    endcase
  end

  ssdf_ram #(
    .WIDTH(MW),
    .DEPTH(SLOTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(meta_rdata)
  );

  ssdf_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(SLOTS)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(item_q.value_in[VALUE_BITS-1:0]),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(val_rdata)
  );

  // Unpack the entry; slots at or above the bump count were never written and read empty
  assign rd_tag     = meta_rdata[2:0];
  assign rd_pend    = meta_rdata[3];
  assign rd_link    = meta_rdata[MW-1:4];
  assign slot_q_ext = CW'(item_q.slot_in);
  assign slot_used  = slot_q_ext < CW'(bump_q);
  assign cur_tag    = slot_used ? rd_tag : TAG_EMPTY;
  assign cur_pend   = slot_used & rd_pend;
  assign type_ok    = item_q.type_id < 3'(TYPE_COUNT);
  assign free_avail = (free_head_q != NIL);
  assign bump_avail = (bump_q != NIL);
  assign alloc_idx  = free_avail ? free_head_q : bump_q;
  assign alloc_ext  = CW'(alloc_idx);

  // Decide the command, write the changed entry back and update the list heads and bump counter
  always_comb begin
    meta_we     = 1'b0;
    meta_waddr  = slot_q_ext[IW-1:0];
    meta_wdata  = meta_rdata;
    val_we      = 1'b0;
    val_waddr   = alloc_idx[IW-1:0];
    bump_d      = bump_q;
    free_head_d = free_head_q;
    dead_head_d = dead_head_q;
    dead_tail_d = dead_tail_q;
    res_d       = '{status: ST_OK, slot_out: '0, value_out: '0};
    if (state_q == S_EXEC) begin
      unique case (item_q.opcode)
        OP_SET: begin
          if (!type_ok) begin
            res_d.status = ST_BAD_TYPE;
          end else if (!free_avail && !bump_avail) begin
            res_d.status = ST_NO_SPACE;
          end else begin
            meta_we        = 1'b1;
            meta_waddr     = alloc_idx[IW-1:0];
            meta_wdata     = {rd_link, 1'b0, item_q.type_id};
            val_we         = 1'b1;
            res_d.slot_out = alloc_ext[9:0];
            if (free_avail) begin
              free_head_d = rd_link;
            end else begin
              bump_d = bump_q + PW'(1);
            end
          end
        end
        OP_GET: begin
          if (!slot_used && (slot_q_ext >= CW'(SLOTS))) begin
            res_d.status = ST_MISMATCH;
          end else if (cur_tag != item_q.type_id) begin
            res_d.status = ST_MISMATCH;
          end else if (!type_ok) begin
            res_d.status = ST_BAD_TYPE;
          end else if (cur_pend) begin
            res_d.status = ST_PENDING;
          end else begin
            res_d.value_out = 64'(val_rdata);
          end
        end
        OP_DEL: begin
          if (!slot_used || (cur_tag == TAG_EMPTY) || cur_pend) begin
            res_d.status = ST_BAD_DEL;
          end else begin
            meta_we     = 1'b1;
            meta_wdata  = {dead_head_q, 1'b1, cur_tag};
            dead_head_d = slot_q_ext[PW-1:0];
            if (dead_head_q == NIL) begin
              dead_tail_d = slot_q_ext[PW-1:0];
            end
          end
        end
        OP_CLEAN: begin
          if ((dead_head_q == NIL) || (dead_tail_q == NIL)) begin
            res_d.status = ST_NO_CLEAN;
          end else begin
            meta_we     = 1'b1;
            meta_waddr  = dead_tail_q[IW-1:0];
            meta_wdata  = {free_head_q, rd_pend, rd_tag};
            free_head_d = dead_head_q;
            dead_head_d = NIL;
            dead_tail_d = NIL;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the sequencer: the read in S_IDLE on accept, then the write-back in S_EXEC
  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state, list heads and the bump counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      bump_q      <= '0;
      free_head_q <= NIL;
      dead_head_q <= NIL;
      dead_tail_q <= NIL;
    end else begin
      state_q     <= state_d;
      done_q      <= busy;
      bump_q      <= bump_d;
      free_head_q <= free_head_d;
      dead_head_q <= dead_head_d;
      dead_tail_q <= dead_tail_d;
    end
  end

  // Capture the command and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (busy) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
